### design/mwsm_pkg.sv
`default_nettype none
package mwsm_pkg;

  localparam int TRIG_TABLE_BITS_DEF = 10;
  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 16;
  localparam int WHEEL_W = 18;
  localparam int TRIG_W  = 15;                        // unsigned table magnitude
  localparam int PROD_W  = 2 * SPEED_W;               // one Q15 product
  localparam int ROT_W   = WHEEL_W;                   // rotated speed width

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 10;
  localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Stage advance enables handed to the datapath modules
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  // Table entry k of round(32768*sin(k*pi/(2N))), clipped to 32767, N = 2^tb, via Q30 Taylor series
  function automatic logic [TRIG_W-1:0] trig_entry(input int unsigned k, input int unsigned tb);
    longint unsigned n;
    longint unsigned kk;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint signed   sum;
    n  = 64'd1 << tb;
    kk = 64'(k);
    if (kk > n) kk = n;
    x    = (kk * HALF_PI_Q30 + (n >> 1)) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= TAYLOR_TERMS; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i];
      if ((i % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) sum = 64'sd32767;
    return sum[TRIG_W-1:0];
  endfunction

endpackage
`default_nettype wire

### design/mwsm_cmd_if.sv
`default_nettype none
interface mwsm_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_forward;
  logic signed [15:0] speed_side;
  logic signed [15:0] turn_rate;
  logic        [15:0] heading_offset;
  logic               zero_force;

  modport source(output valid, speed_forward, speed_side, turn_rate, heading_offset,
                 zero_force, input ready);
  modport sink(input valid, speed_forward, speed_side, turn_rate, heading_offset,
               zero_force, output ready);
endinterface
`default_nettype wire

### design/mwsm_wheel_if.sv
`default_nettype none
interface mwsm_wheel_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] wheel_left_front;
  logic signed [17:0] wheel_left_back;
  logic signed [17:0] wheel_right_back;
  logic signed [17:0] wheel_right_front;
  logic               motors_enabled;

  modport source(output valid, wheel_left_front, wheel_left_back, wheel_right_back,
                 wheel_right_front, motors_enabled, input ready);
  modport sink(input valid, wheel_left_front, wheel_left_back, wheel_right_back,
               wheel_right_front, motors_enabled, output ready);
endinterface
`default_nettype wire

### design/mwsm_trig_rom.sv
`default_nettype none
module mwsm_trig_rom
  import mwsm_pkg::*;
#(
  parameter int TRIG_TABLE_BITS = TRIG_TABLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [TRIG_TABLE_BITS:0]   addr_a,
  input  wire logic [TRIG_TABLE_BITS:0]   addr_b,
  output logic      [TRIG_W-1:0]          data_a,
  output logic      [TRIG_W-1:0]          data_b
);

  localparam int DEPTH = (1 << TRIG_TABLE_BITS) + 1;

  typedef logic [TRIG_W-1:0] rom_arr_t [0:DEPTH-1];

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int i = 0; i < DEPTH; i++) begin
      r[i] = trig_entry(i, TRIG_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  // two synchronous read ports
  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= ROM[addr_a];
      data_b <= ROM[addr_b];
    end
  end

endmodule
`default_nettype wire

### design/mwsm_rotate.sv
`default_nettype none
module mwsm_rotate
  import mwsm_pkg::*;
(
  input  wire logic                      clk,
  input  wire pipe_en_t                  en,
  input  wire logic signed [SPEED_W-1:0] vx,
  input  wire logic signed [SPEED_W-1:0] vy,
  input  wire logic        [1:0]         quad,
  input  wire logic        [TRIG_W-1:0]  tab_a,
  input  wire logic        [TRIG_W-1:0]  tab_b,
  output logic signed      [ROT_W-1:0]   cx_r,
  output logic signed      [ROT_W-1:0]   cy_r
);

  logic signed [SPEED_W-1:0] pos_a, pos_b, sin_nxt, cos_nxt;
  logic signed [PROD_W-1:0]  p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [PROD_W:0]    sum_x, sum_y;
  logic signed [PROD_W:0]    rnd_x, rnd_y;

  assign pos_a = signed'({1'b0, tab_a});
  assign pos_b = signed'({1'b0, tab_b});

  // quadrant folding
  always_comb begin
    case (quad)
      2'd0:    begin sin_nxt = pos_a;  cos_nxt = pos_b;  end
      2'd1:    begin sin_nxt = pos_b;  cos_nxt = -pos_a; end
      2'd2:    begin sin_nxt = -pos_a; cos_nxt = -pos_b; end
      default: begin sin_nxt = -pos_b; cos_nxt = pos_a;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_xc_r <= vx * cos_nxt;
      p_ys_r <= vy * sin_nxt;
      p_xs_r <= vx * sin_nxt;
      p_yc_r <= vy * cos_nxt;
    end
  end

  assign sum_x = PROD_W'(p_xc_r) - PROD_W'(p_ys_r);
  assign sum_y = PROD_W'(p_xs_r) + PROD_W'(p_yc_r);
  // round to nearest, ties toward +inf
  assign rnd_x = (sum_x + (PROD_W+1)'(16384)) >>> 15;
  assign rnd_y = (sum_y + (PROD_W+1)'(16384)) >>> 15;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      cx_r <= rnd_x[ROT_W-1:0];
      cy_r <= rnd_y[ROT_W-1:0];
    end
  end

endmodule
`default_nettype wire

### design/mwsm_mix.sv
`default_nettype none
module mwsm_mix
  import mwsm_pkg::*;
(
  input  wire logic                      clk,
  input  wire pipe_en_t                  en,
  input  wire logic signed [ROT_W-1:0]   cx,
  input  wire logic signed [ROT_W-1:0]   cy,
  input  wire logic signed [SPEED_W-1:0] wz,
  output logic signed      [WHEEL_W-1:0] lf_r,
  output logic signed      [WHEEL_W-1:0] lb_r,
  output logic signed      [WHEEL_W-1:0] rb_r,
  output logic signed      [WHEEL_W-1:0] rf_r
);

  localparam int SUM_W = WHEEL_W + 2;

  function automatic logic signed [WHEEL_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((1 << (WHEEL_W - 1)) - 1);
    lo = -SUM_W'(1 << (WHEEL_W - 1));
    if (v > hi) return hi[WHEEL_W-1:0];
    if (v < lo) return lo[WHEEL_W-1:0];
    return v[WHEEL_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] x_e, y_e, w_e;

  assign x_e = SUM_W'(cx);
  assign y_e = SUM_W'(cy);
  assign w_e = SUM_W'(wz);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      lf_r <= sat(x_e - y_e - w_e);
      lb_r <= sat(x_e + y_e - w_e);
      rb_r <= sat(x_e - y_e + w_e);
      rf_r <= sat(x_e + y_e + w_e);
    end
  end

endmodule
`default_nettype wire

### design/mecanum_wheel_speed_mixer.sv
// Each input transfer passes four registered stages before its result shows on out_wheel.
// Throughput: one command per cycle unless out_wheel stalls; each of the 4 stages advances whenever its
// successor is empty or advancing, so back-pressure stalls without loss.
// Reset: rst_n synchronous, active low; clears stage valid bits only.
// The sine table is a constant ROM (2^TRIG_TABLE_BITS + 1 entries), no load needed.
`default_nettype none
module mecanum_wheel_speed_mixer
  import mwsm_pkg::*;
#(
  parameter int TRIG_TABLE_BITS = TRIG_TABLE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mwsm_cmd_if.sink    in_cmd,
  mwsm_wheel_if.source out_wheel
);

  // Stage 1: operands registered, table read (two ports: k and N-k)
  // Stage 2: quadrant fold + four Q15 products
  // Stage 3: sum and round to cx, cy
  // Stage 4: wheel mix with saturation, output register

  localparam logic [TRIG_TABLE_BITS:0] N_ADDR = (TRIG_TABLE_BITS+1)'(1) << TRIG_TABLE_BITS;

  pipe_en_t en;
  logic v1_r, v2_r, v3_r, v4_r;
  logic stop1_r, stop2_r, stop3_r, stop4_r;
  logic signed [SPEED_W-1:0] vx1_r, vy1_r;
  logic signed [SPEED_W-1:0] wz1_r, wz2_r, wz3_r;
  logic        [1:0]         quad1_r;
  logic        [TRIG_TABLE_BITS:0] k_addr, nk_addr;
  logic        [TRIG_W-1:0]  tab_a, tab_b;
  logic signed [ROT_W-1:0]   cx, cy;

  // Ready ripples back: a stage may load when empty or when it moves on
  assign en.s4 = !v4_r || out_wheel.ready;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;

  assign in_cmd.ready = en.s1;

  // Angle split: quadrant on top, table index below, rest truncated
  assign k_addr  = {1'b0, in_cmd.heading_offset[ANGLE_W-3 -: TRIG_TABLE_BITS]};
  assign nk_addr = N_ADDR - k_addr;

  mwsm_trig_rom #(
    .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (en.s1),
    .addr_a (k_addr),
    .addr_b (nk_addr),
    .data_a (tab_a),
    .data_b (tab_b)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_cmd.valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  // Side-band payload that rides alongside the datapath
  always_ff @(posedge clk) begin
    if (en.s1) begin
      vx1_r   <= in_cmd.speed_forward;
      vy1_r   <= in_cmd.speed_side;
      wz1_r   <= in_cmd.turn_rate;
      quad1_r <= in_cmd.heading_offset[ANGLE_W-1 -: 2];
      stop1_r <= in_cmd.zero_force;
    end
    if (en.s2) begin
      wz2_r   <= wz1_r;
      stop2_r <= stop1_r;
    end
    if (en.s3) begin
      wz3_r   <= wz2_r;
      stop3_r <= stop2_r;
    end
    if (en.s4) stop4_r <= stop3_r;
  end

  mwsm_rotate u_rot (
    .clk   (clk),
    .en    (en),
    .vx    (vx1_r),
    .vy    (vy1_r),
    .quad  (quad1_r),
    .tab_a (tab_a),
    .tab_b (tab_b),
    .cx_r  (cx),
    .cy_r  (cy)
  );

  mwsm_mix u_mix (
    .clk  (clk),
    .en   (en),
    .cx   (cx),
    .cy   (cy),
    .wz   (wz3_r),
    .lf_r (out_wheel.wheel_left_front),
    .lb_r (out_wheel.wheel_left_back),
    .rb_r (out_wheel.wheel_right_back),
    .rf_r (out_wheel.wheel_right_front)
  );

  assign out_wheel.valid          = v4_r;
  assign out_wheel.motors_enabled = !stop4_r;

`ifndef SYNTH
  // reset empties the whole pipe
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !v4_r)
    else $error("pipeline not empty after reset");

  // a stalled output keeps the item behind it
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_wheel.ready && v3_r |=> v4_r && v3_r)
    else $error("item dropped under stall");

  // zero angle in a quadrant reads table ends: sin 0 and full scale
  a_table_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_cmd.valid && in_cmd.ready && (in_cmd.heading_offset[ANGLE_W-3:0] == '0)
    |=> tab_a == '0 && tab_b == TRIG_W'(32767))
    else $error("trig table end entries wrong");

  // stage 1 may not take a new item while it is stuck
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !en.s2 |=> v1_r && $stable(vx1_r) && $stable(quad1_r))
    else $error("stage 1 changed while stalled");
`endif

endmodule
`default_nettype wire
